// File: rtl/assert_macros.svh
// Assertion macros shared by the resampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IFR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("resampler assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IFR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("resampler assertion failed");

`endif

// File: rtl/ifr_pkg.sv
// Types, codes and constants of the integer factor resampler.
package ifr_pkg;

  localparam int SAMPLE_BITS    = 32;
  localparam int MAX_FACTOR_DEF = 16;
  localparam int FACTOR_BITS    = 5;
  localparam int MODE_BITS      = 2;
  localparam int APB_DATA_BITS  = 32;
  localparam int APB_ADDR_BITS  = 3;

  // Register indexes.
  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_FACTOR = 1'b1;

  // Mode codes; bit 1 set selects decimation.
  localparam logic [MODE_BITS-1:0] MODE_LINEAR  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_NEAREST = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_DOWN    = 2'd2;

  localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 5'd1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          final_req;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          run_last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_SEG,
    ST_CLAMP,
    ST_DOWN
  } state_t;

endpackage

// File: rtl/integer_factor_resampler.sv
// Integer factor resampler: linear or nearest upscale and decimation of Q16.16 samples.
// Linear upscale with a previous sample: a restoring divider (step = (cur - prev) / k),
// a fixup state, then one result per cycle while the output is not stalled, k results in all.
// Nearest upscale gives one result per cycle while the output is not stalled; clamped copies add k results.
// A new sample is taken only once the previous one's results are all in the output register.
// Reset (synchronous, active low) sets mode 0, factor 1 and clears all grid progress.
`include "assert_macros.svh"

module integer_factor_resampler
  import ifr_pkg::*;
#(
  parameter int MAX_FACTOR = MAX_FACTOR_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_t                      in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_t                     out_data,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int SW = SAMPLE_BITS;
  localparam int KW = $clog2(MAX_FACTOR + 1);
  localparam int PW = $clog2(MAX_FACTOR);
  localparam int CW = $clog2(SW);

  state_t                 state_r, state_nxt;
  logic [MODE_BITS-1:0]   mode_r;
  logic [FACTOR_BITS-1:0] factor_r;
  logic signed [SW-1:0]   prev_r, prev_nxt;
  logic                   have_prev_r, have_prev_nxt;
  logic [PW-1:0]          pos_r, pos_nxt;
  logic signed [SW-1:0]   held_r, held_nxt;
  logic signed [SW-1:0]   cur_r, cur_nxt;
  logic                   fin_r, fin_nxt;
  logic                   near_r, near_nxt;
  logic [KW-1:0]          k_r, k_nxt;
  logic [KW-1:0]          j_r, j_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [SW-1:0]          quo_r, quo_nxt;
  logic [KW-1:0]          rem_r, rem_nxt;
  logic                   dneg_r, dneg_nxt;
  logic [SW:0]            q_r, q_nxt;
  logic [KW-1:0]          r_r, r_nxt;
  logic [SW:0]            dq_r, dq_nxt;
  logic [KW-1:0]          dr_r, dr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_t                   out_data_r, out_data_nxt;

  logic          in_acc;
  logic          cfg_wr;
  logic [KW-1:0] k_eff;
  logic          gen_valid;
  logic          gen_load;
  out_t          gen_data;

  logic [SW:0]   diff;
  logic [SW:0]   diff_mag;
  logic [KW:0]   trial;
  logic          trial_ge;
  logic [KW:0]   rsum;
  logic          rcarry;
  logic [KW-1:0] half;
  logic          bump;
  logic [SW:0]   lin_val;
  logic          near_prev;
  logic          j_last;
  logic [KW-1:0] pos_inc;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_MODE:   prdata = APB_DATA_BITS'(mode_r);
      REG_FACTOR: prdata = APB_DATA_BITS'(factor_r);
      default:    prdata = '0;
    endcase
  end

  // Zero acts as one, values above the maximum saturate.
  always_comb begin
    if (factor_r == '0) begin
      k_eff = KW'(1);
    end else if (int'(factor_r) > MAX_FACTOR) begin
      k_eff = KW'(MAX_FACTOR);
    end else begin
      k_eff = KW'(factor_r);
    end
  end

  // Datapath pieces shared by the sequencer.
  assign diff     = {in_data.sample[SW-1], in_data.sample} - {prev_r[SW-1], prev_r};
  assign diff_mag = diff[SW] ? -diff : diff;
  assign trial    = {rem_r, quo_r[SW-1]};
  assign trial_ge = (trial >= {1'b0, k_r});
  assign rsum     = {1'b0, r_r} + {1'b0, dr_r};
  assign rcarry   = (rsum >= {1'b0, k_r});
  assign half     = k_r >> 1;
  // Ties round away from zero; q carries the sign since 0 <= r < k.
  assign bump     = q_r[SW] ? (r_r > half) : (r_r >= (k_r - half));
  assign lin_val  = q_r + (SW+1)'(bump);
  assign near_prev = ({1'b0, j_r} << 1) < {1'b0, k_r};
  assign j_last   = (j_r == (k_r - KW'(1)));
  assign pos_inc  = KW'(pos_r) + KW'(1);

  assign gen_valid = (state_r == ST_SEG) || (state_r == ST_CLAMP) || (state_r == ST_DOWN);
  assign gen_load  = gen_valid && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    pos_nxt       = pos_r;
    held_nxt      = held_r;
    cur_nxt       = cur_r;
    fin_nxt       = fin_r;
    near_nxt      = near_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dneg_nxt      = dneg_r;
    q_nxt         = q_r;
    r_nxt         = r_r;
    dq_nxt        = dq_r;
    dr_nxt        = dr_r;
    gen_data      = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cur_nxt  = in_data.sample;
          fin_nxt  = in_data.final_req;
          k_nxt    = k_eff;
          near_nxt = (mode_r == MODE_NEAREST);
          j_nxt    = '0;
          if ((mode_r & MODE_DOWN) != '0) begin
            if (pos_r == '0) begin
              held_nxt = in_data.sample;
            end
            if (pos_inc >= k_eff) begin
              pos_nxt   = '0;
              state_nxt = ST_DOWN;
            end else begin
              pos_nxt = pos_inc[PW-1:0];
            end
            if (in_data.final_req) begin
              pos_nxt       = '0;
              have_prev_nxt = 1'b0;
            end
          end else begin
            prev_nxt      = in_data.sample;
            have_prev_nxt = !in_data.final_req;
            q_nxt         = {prev_r[SW-1], prev_r};
            r_nxt         = '0;
            quo_nxt       = diff_mag[SW-1:0];
            rem_nxt       = '0;
            cnt_nxt       = '0;
            dneg_nxt      = diff[SW];
            if (have_prev_r) begin
              state_nxt = (mode_r == MODE_NEAREST) ? ST_SEG : ST_DIV;
            end else if (in_data.final_req) begin
              state_nxt = ST_CLAMP;
            end
            if (in_data.final_req) begin
              pos_nxt = '0;
            end
          end
        end
      end

      // One restoring division bit per cycle: |cur - prev| / k.
      ST_DIV: begin
        rem_nxt = trial_ge ? KW'(trial - {1'b0, k_r}) : trial[KW-1:0];
        quo_nxt = {quo_r[SW-2:0], trial_ge};
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(SW - 1)) begin
          state_nxt = ST_FIX;
        end
      end

      // Turn the magnitude quotient into a floor quotient and a non-negative remainder.
      ST_FIX: begin
        if (dneg_r && (rem_r != '0)) begin
          dq_nxt = -({1'b0, quo_r} + (SW+1)'(1));
          dr_nxt = k_r - rem_r;
        end else if (dneg_r) begin
          dq_nxt = -{1'b0, quo_r};
          dr_nxt = '0;
        end else begin
          dq_nxt = {1'b0, quo_r};
          dr_nxt = rem_r;
        end
        state_nxt = ST_SEG;
      end

      ST_SEG: begin
        if (near_r) begin
          gen_data.value = near_prev ? q_r[SW-1:0] : cur_r;
        end else begin
          gen_data.value = lin_val[SW-1:0];
        end
        gen_data.run_last = j_last && !fin_r;
        if (gen_load) begin
          if (!near_r) begin
            r_nxt = rcarry ? KW'(rsum - {1'b0, k_r}) : rsum[KW-1:0];
            q_nxt = q_r + dq_r + (SW+1)'(rcarry);
          end
          j_nxt = j_r + KW'(1);
          if (j_last) begin
            j_nxt     = '0;
            state_nxt = fin_r ? ST_CLAMP : ST_IDLE;
          end
        end
      end

      // Clamped edge: k copies of the final sample.
      ST_CLAMP: begin
        gen_data.value    = cur_r;
        gen_data.run_last = j_last;
        if (gen_load) begin
          j_nxt = j_r + KW'(1);
          if (j_last) begin
            j_nxt     = '0;
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_DOWN: begin
        gen_data.value    = held_r;
        gen_data.run_last = 1'b1;
        if (gen_load) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_data_nxt = out_data_r;
    if (gen_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = gen_data;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_LINEAR;
      factor_r    <= FACTOR_RESET;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      pos_r       <= '0;
      held_r      <= '0;
      j_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      pos_r       <= pos_nxt;
      held_r      <= held_nxt;
      j_r         <= j_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        case (paddr[2])
          REG_MODE:   mode_r   <= pwdata[MODE_BITS-1:0];
          REG_FACTOR: factor_r <= pwdata[FACTOR_BITS-1:0];
          default:    mode_r   <= mode_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    fin_r      <= fin_nxt;
    near_r     <= near_nxt;
    k_r        <= k_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    dneg_r     <= dneg_nxt;
    q_r        <= q_nxt;
    r_r        <= r_nxt;
    dq_r       <= dq_nxt;
    dr_r       <= dr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `IFR_ASSERT_NXT(a_lin_divides, clk, rst_n, in_acc && (mode_r == MODE_LINEAR) && have_prev_r, state_r == ST_DIV)
  `IFR_ASSERT_IMP(a_rem_bound, clk, rst_n, state_r == ST_SEG, r_r < k_r)
  `IFR_ASSERT_IMP(a_count_bound, clk, rst_n, state_r == ST_SEG || state_r == ST_CLAMP, j_r < k_r)
  `IFR_ASSERT_NXT(a_last_to_idle, clk, rst_n, gen_load && gen_data.run_last, state_r == ST_IDLE)

endmodule
